FILE: src/assert_macros.svh
// Assertion macros used by iterated_des_password_hash.
// Assertions use the clock clk_i and the active-low reset rst_ni of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/ides_pkg.sv
// DES tables, permutation functions and the pipeline stage type.
// No dependencies.
package ides_pkg;

  localparam int unsigned ROUNDS = 16;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic [55:0] cd;
    logic [63:0] expected;
  } stage_t;

  localparam int unsigned IP_TAB[64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam int unsigned FP_TAB[64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam int unsigned E_TAB[48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam int unsigned P_TAB[32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam int unsigned PC1_TAB[56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam int unsigned PC2_TAB[48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam int unsigned ROT_TAB[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] SBOX[8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = v[64-IP_TAB[i]];
    return res;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] v);
    logic [63:0] res;
    for (int i = 0; i < 64; i++) res[63-i] = v[64-FP_TAB[i]];
    return res;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] v);
    logic [55:0] res;
    for (int i = 0; i < 56; i++) res[55-i] = v[64-PC1_TAB[i]];
    return res;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] v);
    logic [47:0] res;
    for (int i = 0; i < 48; i++) res[47-i] = v[56-PC2_TAB[i]];
    return res;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] res;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) res[31-i] = s[32-P_TAB[i]];
    return res;
  endfunction

endpackage

FILE: src/ides_in_if.sv
// Request channel: key, plaintext block and expected digest.
// Depends on nothing.
interface ides_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_block;
  logic [63:0] plain_block;
  logic [63:0] expected_digest;
  modport source (output valid, key_block, plain_block, expected_digest, input ready);
  modport sink (input valid, key_block, plain_block, expected_digest, output ready);
endinterface

FILE: src/ides_out_if.sv
// Result channel: digest and match flag.
// Depends on nothing.
interface ides_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;
  logic        match;
  modport source (output valid, digest, match, input ready);
  modport sink (input valid, digest, match, output ready);
endinterface

FILE: src/ides_stage.sv
// One registered DES round with its key schedule step.
// Depends on ides_pkg.
module ides_stage #(
  parameter int unsigned ROUND = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ides_pkg::stage_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  output ides_pkg::stage_t data_o,
  input  logic            ready_i
);

  localparam int unsigned SHIFT = ides_pkg::ROT_TAB[ROUND];

  logic             valid_q;
  ides_pkg::stage_t data_q, data_d;
  logic [27:0]      c_rot, d_rot;
  logic [31:0]      new_r;

  always_comb begin
    c_rot = {data_i.cd[55-SHIFT:28], data_i.cd[55 -: SHIFT]};
    d_rot = {data_i.cd[27-SHIFT:0], data_i.cd[27 -: SHIFT]};
    new_r = data_i.l ^ ides_pkg::feistel(data_i.r, ides_pkg::perm_pc2({c_rot, d_rot}));
    data_d.cd = {c_rot, d_rot};
    data_d.expected = data_i.expected;
    // The last round of each encryption leaves the halves unswapped, as the next one wants.
    if (ROUND == ides_pkg::ROUNDS - 1) begin
      data_d.l = new_r;
      data_d.r = data_i.r;
    end else begin
      data_d.l = data_i.r;
      data_d.r = new_r;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: src/iterated_des_password_hash.sv
// Iterated DES password hash: ITERATIONS DES encryptions under one key, fully pipelined.
// Depends on ides_pkg, ides_in_if, ides_out_if, ides_stage and assert_macros.svh.
//
//  channel | direction | fields
//  req_i   | in        | key_block, plain_block, expected_digest
//  rsp_o   | out       | digest, match
//
// One request enters per cycle unless the pipeline is stalled; there is one register per DES round.
// The last round register is the output register; digest and match come from it.
// Reset clears all stage valid bits; data registers are not reset.
// Each stage is ready when empty or when the next stage moves, so bubbles close up under a stall.
`include "assert_macros.svh"
module iterated_des_password_hash #(
  parameter int unsigned ITERATIONS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ides_in_if.sink    req_i,
  ides_out_if.source rsp_o
);

  localparam int unsigned STAGES = ITERATIONS * ides_pkg::ROUNDS;

  logic             valid_s [STAGES+1];
  logic             ready_s [STAGES+1];
  ides_pkg::stage_t data_s  [STAGES+1];
  logic [63:0]      ip_blk;

  assign ip_blk          = ides_pkg::perm_ip(req_i.plain_block);
  assign valid_s[0]      = req_i.valid;
  assign req_i.ready     = ready_s[0];
  assign data_s[0].l     = ip_blk[63:32];
  assign data_s[0].r     = ip_blk[31:0];
  assign data_s[0].cd    = ides_pkg::perm_pc1(req_i.key_block);
  assign data_s[0].expected = req_i.expected_digest;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    ides_stage #(
      .ROUND (g % ides_pkg::ROUNDS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .data_i  (data_s[g]),
      .ready_o (ready_s[g]),
      .valid_o (valid_s[g+1]),
      .data_o  (data_s[g+1]),
      .ready_i (ready_s[g+1])
    );
  end

  assign ready_s[STAGES] = rsp_o.ready;
  assign rsp_o.valid     = valid_s[STAGES];
  assign rsp_o.digest    = ides_pkg::perm_fp({data_s[STAGES].l, data_s[STAGES].r});
  assign rsp_o.match     = (rsp_o.digest == data_s[STAGES].expected);

  `ASSERT_ALWAYS(a_ready_when_drained, !rsp_o.valid |-> req_i.ready, "input stalled on empty output")
  `ASSERT_ALWAYS(a_ready_when_taken, rsp_o.ready |-> req_i.ready, "input stalled while output moves")
  `ASSERT_NEXT(a_hold_stalled, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_o.digest), "stalled result changed")

endmodule
